### hdl/smooth_vertex_normal_accumulator_defines.svh
// assertion macros for the vertex normal accumulator
// used by the top level only, no other dependencies
`ifndef SMOOTH_VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH
`define SMOOTH_VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SVNA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("svna assertion failed");
// next-cycle implication
`define SVNA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("svna assertion failed");
`else
`define SVNA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SVNA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/svna_pkg.sv
// shared types and constants of the vertex normal accumulator
// no dependencies
package svna_pkg;
	localparam int VERTICES_DEF         = 1024;
	localparam int MAX_FACE_CORNERS_DEF = 4;
	localparam int COORD_BITS_DEF       = 16;

	localparam int CORNER_FIELDS = 4;
	localparam int IDX_BITS      = 10;
	localparam int FIELD_BITS    = 16;
	localparam int FSIZE_BITS    = 3;
	localparam int ACC_BITS      = 48;
	localparam int UNIT_BITS     = 16;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_LOAD  = 2'd0;
	localparam mode_t MODE_FACE  = 2'd1;
	localparam mode_t MODE_READ  = 2'd2;
	localparam mode_t MODE_SPARE = 2'd3;

	typedef struct packed {
		logic signed [UNIT_BITS-1:0] z;
		logic signed [UNIT_BITS-1:0] y;
		logic signed [UNIT_BITS-1:0] x;
	} unit_vec_t;
endpackage

### hdl/smooth_vertex_normal_accumulator.sv
// top level of the vertex normal accumulator: sequencer and both memories
// depends on svna_pkg, svna_ram, svna_cross, svna_norm and the defines header
//
// usage: words enter on the in channel (in_valid / in_stall) and results leave
// on the out channel (out_valid / out_stall); a word moves when valid is high
// and stall is low. one word is worked on at a time.
// load word (mode 0): writes the position and zeroes the vertex accumulator
//   in the same cycle, no result.
// face word (mode 1): 3 vertex reads + cross product on one shared multiplier,
//   then a read-modify-write of the accumulator per corner; short or
//   out-of-range faces are dropped without any memory reads.
// read word (mode 2): one accumulator read, then the normalizer: up to 17
//   prescale shifts, a sum of squares, 32 root steps and three divides. a
//   zero accumulator or an out-of-range index gives a zero result without
//   the root and the divides.
// after reset the block sweeps the accumulator memory to zero, one entry per
//   cycle, with in_stall held high.
// the result sits in an output register; a stalled receiver holds it there
//   while the block keeps taking new words until the next result is ready.
`include "smooth_vertex_normal_accumulator_defines.svh"
module smooth_vertex_normal_accumulator #(
	parameter int VERTICES         = svna_pkg::VERTICES_DEF,
	parameter int MAX_FACE_CORNERS = svna_pkg::MAX_FACE_CORNERS_DEF,
	parameter int COORD_BITS       = svna_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  svna_pkg::mode_t                        mode,
	input  logic [svna_pkg::IDX_BITS-1:0]          vertex_index,
	input  logic signed [svna_pkg::FIELD_BITS-1:0] coord_x,
	input  logic signed [svna_pkg::FIELD_BITS-1:0] coord_y,
	input  logic signed [svna_pkg::FIELD_BITS-1:0] coord_z,
	input  logic [svna_pkg::FSIZE_BITS-1:0]        face_size,
	input  logic [svna_pkg::IDX_BITS-1:0]          corner_0,
	input  logic [svna_pkg::IDX_BITS-1:0]          corner_1,
	input  logic [svna_pkg::IDX_BITS-1:0]          corner_2,
	input  logic [svna_pkg::IDX_BITS-1:0]          corner_3,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [svna_pkg::IDX_BITS-1:0]          normal_index,
	output logic signed [svna_pkg::UNIT_BITS-1:0]  normal_x,
	output logic signed [svna_pkg::UNIT_BITS-1:0]  normal_y,
	output logic signed [svna_pkg::UNIT_BITS-1:0]  normal_z
);
	import svna_pkg::*;

	localparam int AW   = $clog2(VERTICES);
	localparam int VW   = 3 * COORD_BITS;
	localparam int NW   = 2 * COORD_BITS + 3;
	localparam int SW   = ((NW > ACC_BITS) ? NW : ACC_BITS) + 1;
	localparam int NLIM = (MAX_FACE_CORNERS < CORNER_FIELDS) ? MAX_FACE_CORNERS
		: CORNER_FIELDS;
	localparam logic signed [SW-1:0] ACC_HI =
		{{(SW-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
	localparam logic signed [SW-1:0] ACC_LO =
		{{(SW-ACC_BITS+1){1'b1}}, {(ACC_BITS-1){1'b0}}};

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_VRD   = 4'd2;
	localparam logic [3:0] ST_CROSS = 4'd3;
	localparam logic [3:0] ST_ARD   = 4'd4;
	localparam logic [3:0] ST_AWR   = 4'd5;
	localparam logic [3:0] ST_NWAIT = 4'd6;
	localparam logic [3:0] ST_NORM  = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	logic [3:0]            state_q;
	logic [AW-1:0]         clr_q;
	logic [2:0]            cnt_q;
	logic [FSIZE_BITS-1:0] n_q;
	logic [IDX_BITS-1:0]   corner_q [CORNER_FIELDS];
	logic [VW-1:0]         vtx_q [3];
	logic [IDX_BITS-1:0]   idx_q;
	unit_vec_t             res_q;

	logic                  out_valid_q;
	logic [IDX_BITS-1:0]   out_idx_q;
	unit_vec_t             out_vec_q;

	logic                  accept;
	logic [FSIZE_BITS-1:0] n_in;
	logic [IDX_BITS-1:0]   cur_corner;
	logic                  cur_ok, vi_ok, face_ok;

	// memory ports
	logic                  vtx_we;
	logic [AW-1:0]         vtx_raddr;
	logic [VW-1:0]         vtx_wdata, vtx_rdata;
	logic                  acc_we;
	logic [AW-1:0]         acc_waddr, acc_raddr;
	logic [3*ACC_BITS-1:0] acc_wdata, acc_rdata, acc_sum;

	logic                  cross_start, cross_done;
	logic signed [NW-1:0]  nx, ny, nz;
	logic                  norm_start, norm_done;
	unit_vec_t             norm_res;
	logic                  out_load;

	function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] acc,
		input logic signed [NW-1:0] inc);
		logic signed [SW-1:0] s;
		s = SW'(signed'(acc)) + SW'(inc);
		if (s > ACC_HI) begin
			return ACC_HI[ACC_BITS-1:0];
		end else if (s < ACC_LO) begin
			return ACC_LO[ACC_BITS-1:0];
		end
		return s[ACC_BITS-1:0];
	endfunction

	function automatic logic in_range(input logic [IDX_BITS-1:0] v);
		return 32'(v) < VERTICES;
	endfunction

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		n_in = face_size;
		if (n_in > FSIZE_BITS'(NLIM)) begin
			n_in = FSIZE_BITS'(NLIM);
		end
		vi_ok      = in_range(vertex_index);
		face_ok    = (n_in >= FSIZE_BITS'(3)) && in_range(corner_0)
			&& in_range(corner_1) && in_range(corner_2);
		cur_corner = corner_q[cnt_q[1:0]];
		cur_ok     = in_range(cur_corner);
		out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	end

	// vertex store: written on load, read per corner while fetching a face
	assign vtx_we    = accept && (mode == MODE_LOAD) && vi_ok;
	assign vtx_wdata = {COORD_BITS'($unsigned(coord_z)), COORD_BITS'($unsigned(coord_y)),
		COORD_BITS'($unsigned(coord_x))};
	assign vtx_raddr = AW'(cur_corner);

	// accumulator store: sweep, load clear, or read-modify-write of a corner
	always_comb begin
		acc_sum = {sat_add(acc_rdata[2*ACC_BITS +: ACC_BITS], nz),
			sat_add(acc_rdata[ACC_BITS +: ACC_BITS], ny),
			sat_add(acc_rdata[0 +: ACC_BITS], nx)};
		acc_we    = 1'b0;
		acc_waddr = AW'(vertex_index);
		acc_wdata = '0;
		acc_raddr = (state_q == ST_IDLE) ? AW'(vertex_index) : AW'(cur_corner);
		case (state_q)
			ST_CLR: begin
				acc_we    = 1'b1;
				acc_waddr = clr_q;
			end
			ST_IDLE: begin
				acc_we = vtx_we;
			end
			ST_AWR: begin
				acc_we    = 1'b1;
				acc_waddr = AW'(cur_corner);
				acc_wdata = acc_sum;
			end
			default: ;
		endcase
	end

	svna_ram #(.WIDTH(VW), .DEPTH(VERTICES)) u_vtx_ram (
		.clk   (clk),
		.we    (vtx_we),
		.waddr (AW'(vertex_index)),
		.wdata (vtx_wdata),
		.raddr (vtx_raddr),
		.rdata (vtx_rdata)
	);

	svna_ram #(.WIDTH(3*ACC_BITS), .DEPTH(VERTICES)) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.raddr (acc_raddr),
		.rdata (acc_rdata)
	);

	// the third position lands in vtx_q as the fetch ends, start on entry to ST_CROSS
	assign cross_start = (state_q == ST_CROSS) && (cnt_q == 3'd4);

	svna_cross #(.COORD_BITS(COORD_BITS)) u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cross_start),
		.v0     (vtx_q[0]),
		.v1     (vtx_q[1]),
		.v2     (vtx_q[2]),
		.done   (cross_done),
		.nx     (nx),
		.ny     (ny),
		.nz     (nz)
	);

	assign norm_start = (state_q == ST_NWAIT);

	svna_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.ax     (signed'(acc_rdata[0 +: ACC_BITS])),
		.ay     (signed'(acc_rdata[ACC_BITS +: ACC_BITS])),
		.az     (signed'(acc_rdata[2*ACC_BITS +: ACC_BITS])),
		.done   (norm_done),
		.res    (norm_res)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			corner_q[0] <= corner_0;
			corner_q[1] <= corner_1;
			corner_q[2] <= corner_2;
			corner_q[3] <= corner_3;
			n_q         <= n_in;
			idx_q       <= vertex_index;
			res_q       <= '0;
		end
		if (state_q == ST_VRD && cnt_q != 3'd0) begin
			vtx_q[2'(cnt_q - 3'd1)] <= vtx_rdata;
		end
		if (state_q == ST_NORM && norm_done) begin
			res_q <= norm_res;
		end
		if (out_load) begin
			out_idx_q <= idx_q;
			out_vec_q <= res_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(VERTICES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						case (mode)
							MODE_FACE: begin
								if (face_ok) begin
									state_q <= ST_VRD;
								end
							end
							MODE_READ: state_q <= vi_ok ? ST_NWAIT : ST_OUT;
							default: ;
						endcase
					end
				end
				ST_VRD: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd3) begin
						state_q <= ST_CROSS;
					end
				end
				ST_CROSS: begin
					cnt_q <= '0;
					if (cross_done) begin
						state_q <= ST_ARD;
					end
				end
				ST_ARD: begin
					if (cnt_q >= n_q) begin
						state_q <= ST_IDLE;
					end else if (!cur_ok) begin
						cnt_q <= cnt_q + 3'd1;
					end else begin
						state_q <= ST_AWR;
					end
				end
				ST_AWR: begin
					cnt_q   <= cnt_q + 3'd1;
					state_q <= ST_ARD;
				end
				ST_NWAIT: state_q <= ST_NORM;
				ST_NORM: begin
					if (norm_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign normal_index = out_idx_q;
	assign normal_x     = out_vec_q.x;
	assign normal_y     = out_vec_q.y;
	assign normal_z     = out_vec_q.z;

	// the reset sweep writes only zeros
	`SVNA_ASSERT_IMPLY(a_clr_zero, clk, arst_n, state_q == ST_CLR, acc_we && acc_wdata == '0)
	// unit results arrive only while the sequencer waits for them
	`SVNA_ASSERT_IMPLY(a_norm_done, clk, arst_n, norm_done, state_q == ST_NORM)
	`SVNA_ASSERT_IMPLY(a_cross_done, clk, arst_n, cross_done, state_q == ST_CROSS)
	// an accumulator update always stays within the face's corners
	`SVNA_ASSERT_IMPLY(a_awr_corner, clk, arst_n, state_q == ST_AWR, cnt_q < n_q && cur_ok)
endmodule

### hdl/svna_ram.sv
// generic simple dual port ram, one write and one registered read
// no dependencies
module svna_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hdl/svna_cross.sv
// face normal unit: (v2-v1) x (v0-v1) with one shared multiplier
// depends on svna_pkg
module svna_cross #(
	parameter int COORD_BITS = svna_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [3*COORD_BITS-1:0]       v0,
	input  logic [3*COORD_BITS-1:0]       v1,
	input  logic [3*COORD_BITS-1:0]       v2,
	output logic                          done,
	output logic signed [2*COORD_BITS+2:0] nx,
	output logic signed [2*COORD_BITS+2:0] ny,
	output logic signed [2*COORD_BITS+2:0] nz
);
	import svna_pkg::*;

	localparam int D  = COORD_BITS + 1;
	localparam int NW = 2 * D + 1;

	logic signed [D-1:0]     a_q [3];
	logic signed [D-1:0]     b_q [3];
	logic signed [2*D-1:0]   prod_q;
	logic signed [NW-1:0]    nx_q, ny_q, nz_q;
	logic [2:0]              cnt_q;
	logic                    run_q, done_q;
	logic signed [D-1:0]     op_a, op_b;
	logic [2:0]              tag;

	// product schedule: a1b2-a2b1, a2b0-a0b2, a0b1-a1b0
	always_comb begin
		op_a = a_q[0];
		op_b = b_q[0];
		case (cnt_q)
			3'd0: begin op_a = a_q[1]; op_b = b_q[2]; end
			3'd1: begin op_a = a_q[2]; op_b = b_q[1]; end
			3'd2: begin op_a = a_q[2]; op_b = b_q[0]; end
			3'd3: begin op_a = a_q[0]; op_b = b_q[2]; end
			3'd4: begin op_a = a_q[0]; op_b = b_q[1]; end
			3'd5: begin op_a = a_q[1]; op_b = b_q[0]; end
			default: begin op_a = a_q[0]; op_b = b_q[0]; end
		endcase
		tag = cnt_q - 3'd1;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 3; i++) begin
				a_q[i] <= D'(signed'(v2[i*COORD_BITS +: COORD_BITS]))
					- D'(signed'(v1[i*COORD_BITS +: COORD_BITS]));
				b_q[i] <= D'(signed'(v0[i*COORD_BITS +: COORD_BITS]))
					- D'(signed'(v1[i*COORD_BITS +: COORD_BITS]));
			end
			nx_q <= '0;
			ny_q <= '0;
			nz_q <= '0;
		end else if (run_q) begin
			prod_q <= op_a * op_b;
			if (cnt_q != 3'd0) begin
				case (tag)
					3'd0: nx_q <= nx_q + NW'(prod_q);
					3'd1: nx_q <= nx_q - NW'(prod_q);
					3'd2: ny_q <= ny_q + NW'(prod_q);
					3'd3: ny_q <= ny_q - NW'(prod_q);
					3'd4: nz_q <= nz_q + NW'(prod_q);
					3'd5: nz_q <= nz_q - NW'(prod_q);
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == 3'd6) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	assign done = done_q;
	assign nx   = nx_q;
	assign ny   = ny_q;
	assign nz   = nz_q;
endmodule

### hdl/svna_norm.sv
// normalizer: prescale, sum of squares, bit-serial root and divides
// depends on svna_pkg
module svna_norm (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [svna_pkg::ACC_BITS-1:0] ax,
	input  logic signed [svna_pkg::ACC_BITS-1:0] ay,
	input  logic signed [svna_pkg::ACC_BITS-1:0] az,
	output logic                                 done,
	output svna_pkg::unit_vec_t                  res
);
	import svna_pkg::*;

	localparam logic [2:0] N_IDLE  = 3'd0;
	localparam logic [2:0] N_MAX   = 3'd1;
	localparam logic [2:0] N_SHIFT = 3'd2;
	localparam logic [2:0] N_SQ    = 3'd3;
	localparam logic [2:0] N_SQRT  = 3'd4;
	localparam logic [2:0] N_DSET  = 3'd5;
	localparam logic [2:0] N_DIV   = 3'd6;
	localparam logic [2:0] N_FIN   = 3'd7;

	logic [2:0]          st_q;
	logic [ACC_BITS-1:0] mag_q [3];
	logic [2:0]          neg_q;
	logic [ACC_BITS-1:0] m_q;
	logic [61:0]         prod_q;
	logic [63:0]         s_q, root_q, bit_q;
	logic [31:0]         len_q, rem_q;
	logic [16:0]         lo_q, quo_q;
	logic [4:0]          cnt_q;
	logic [1:0]          idx_q;
	logic [UNIT_BITS-1:0] r_q [3];
	logic                done_q;

	logic [63:0] trial, root_nx;
	logic        take;
	logic [46:0] num;
	logic [32:0] dtrial;
	logic        qbit;
	logic [ACC_BITS-1:0] m_nx;
	logic [UNIT_BITS-1:0] r_sat;

	always_comb begin
		trial   = root_q + bit_q;
		take    = s_q >= trial;
		root_nx = take ? ((root_q >> 1) + bit_q) : (root_q >> 1);
		num     = {1'b0, mag_q[idx_q][30:0], 15'b0} + 47'(len_q >> 1);
		dtrial  = {rem_q, lo_q[16]};
		qbit    = dtrial >= {1'b0, len_q};
		m_nx    = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
		if (mag_q[2] > m_nx) begin
			m_nx = mag_q[2];
		end
		// negative side may reach -1.0, positive side stops at just below
		if (neg_q[idx_q]) begin
			r_sat = UNIT_BITS'(17'd0 - quo_q);
		end else if (quo_q > 17'd32767) begin
			r_sat = 16'h7fff;
		end else begin
			r_sat = quo_q[15:0];
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			N_IDLE: begin
				if (start) begin
					mag_q[0] <= ax[ACC_BITS-1] ? ACC_BITS'(-ax) : ACC_BITS'(ax);
					mag_q[1] <= ay[ACC_BITS-1] ? ACC_BITS'(-ay) : ACC_BITS'(ay);
					mag_q[2] <= az[ACC_BITS-1] ? ACC_BITS'(-az) : ACC_BITS'(az);
					neg_q    <= {az[ACC_BITS-1], ay[ACC_BITS-1], ax[ACC_BITS-1]};
				end
			end
			N_MAX: begin
				m_q <= m_nx;
			end
			N_SHIFT: begin
				if (m_q == '0) begin
					for (int i = 0; i < 3; i++) r_q[i] <= '0;
				end else if (m_q[ACC_BITS-1:31] != '0) begin
					m_q <= m_q >> 1;
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
				end else begin
					s_q <= '0;
				end
			end
			N_SQ: begin
				if (idx_q != 2'd3) begin
					prod_q <= mag_q[idx_q][30:0] * mag_q[idx_q][30:0];
				end
				if (idx_q != 2'd0) begin
					s_q <= s_q + 64'(prod_q);
				end
				if (idx_q == 2'd3) begin
					root_q <= '0;
					bit_q  <= 64'h4000_0000_0000_0000;
				end
			end
			N_SQRT: begin
				if (take) begin
					s_q <= s_q - trial;
				end
				root_q <= root_nx;
				bit_q  <= bit_q >> 2;
				len_q  <= root_nx[31:0];
			end
			N_DSET: begin
				rem_q <= 32'(num[46:17]);
				lo_q  <= num[16:0];
				quo_q <= '0;
			end
			N_DIV: begin
				rem_q <= qbit ? 32'(dtrial - {1'b0, len_q}) : dtrial[31:0];
				lo_q  <= lo_q << 1;
				quo_q <= {quo_q[15:0], qbit};
			end
			N_FIN: begin
				r_q[idx_q] <= r_sat;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= N_IDLE;
			cnt_q  <= '0;
			idx_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				N_IDLE: begin
					if (start) begin
						st_q <= N_MAX;
					end
				end
				N_MAX: st_q <= N_SHIFT;
				N_SHIFT: begin
					if (m_q == '0) begin
						done_q <= 1'b1;
						st_q   <= N_IDLE;
					end else if (m_q[ACC_BITS-1:31] == '0) begin
						idx_q <= '0;
						st_q  <= N_SQ;
					end
				end
				N_SQ: begin
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'd3) begin
						cnt_q <= '0;
						st_q  <= N_SQRT;
					end
				end
				N_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						idx_q <= '0;
						st_q  <= N_DSET;
					end
				end
				N_DSET: begin
					cnt_q <= '0;
					st_q  <= N_DIV;
				end
				N_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) begin
						st_q <= N_FIN;
					end
				end
				N_FIN: begin
					if (idx_q == 2'd2) begin
						done_q <= 1'b1;
						st_q   <= N_IDLE;
					end else begin
						idx_q <= idx_q + 2'd1;
						st_q  <= N_DSET;
					end
				end
				default: st_q <= N_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign res.x = r_q[0];
	assign res.y = r_q[1];
	assign res.z = r_q[2];
endmodule
